FILE: rtl/drls_pkg.sv
package drls_pkg;

  localparam int MaxSources = 4;
  localparam int MaxSpans   = 64;
  localparam int LineBits   = 9;
  localparam int SampleBits = 11;

  localparam int SrcBits   = 2;
  localparam int TabBits   = 3;
  localparam int SpanIdx   = $clog2(MaxSpans);
  localparam int CntBits   = $clog2(MaxSpans + 1);
  localparam int AddrBits  = TabBits + SpanIdx;
  localparam int EntryBits = LineBits + 2 * SampleBits;
  localparam int LineWide  = LineBits + 2;

  localparam logic [1:0] MODE_CLEAR   = 2'd0;
  localparam logic [1:0] MODE_LOAD    = 2'd1;
  localparam logic [1:0] MODE_QUALITY = 2'd2;
  localparam logic [1:0] MODE_QUERY   = 2'd3;

  localparam logic [1:0] REG_IS_PAL     = 2'd0;
  localparam logic [1:0] REG_INTRA_ONLY = 2'd1;
  localparam logic [1:0] REG_FIRST_LINE = 2'd2;
  localparam logic [1:0] REG_LAST_LINE  = 2'd3;

  typedef struct packed {
    logic [1:0]            mode;
    logic                  field_second;
    logic [1:0]            source_index;
    logic [LineBits-1:0]   line_number;
    logic [SampleBits-1:0] span_start;
    logic [SampleBits-1:0] span_end;
    logic [15:0]           quality_value;
    logic                  this_field_first;
    logic                  match_chroma;
    logic                  in_colour_burst;
    logic [3:0]            source_mask;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [1:0]          best_source;
    logic                from_same_field;
    logic [LineBits-1:0] best_line;
    logic [9:0]          frame_distance;
    logic [15:0]         best_quality;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch query item
    logic do_clear;
    logic do_load;
    logic do_quality;
    logic start_dir;   // init line for current direction
    logic read_entry;  // move to next table entry
    logic next_line;   // step line
    logic take;        // line free: compare into pick
    logic next_dir;    // move to next direction/source
    logic result;      // load output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_clear;
    logic is_load;
    logic is_quality;
    logic is_query;
    logic in_range;
    logic hit;         // entry overlaps
    logic last_entry;  // entry index at table count
    logic dir_enabled; // current source/dir active
    logic last_dir;
  } dp_stat_t;

endpackage

FILE: rtl/drls_ram.sv
module drls_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/drls_datapath.sv
module drls_datapath import drls_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [LineBits-1:0] cfg_data,
  input  in_item_t  in_item,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_item_t res
);

  // configuration
  logic                is_pal, intra_only;
  logic [LineBits-1:0] first_line, last_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      is_pal     <= 1'b1;
      intra_only <= 1'b0;
      first_line <= LineBits'(22);
      last_line  <= LineBits'(308);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_IS_PAL:     is_pal     <= cfg_data[0];
        REG_INTRA_ONLY: intra_only <= cfg_data[0];
        REG_FIRST_LINE: first_line <= cfg_data;
        REG_LAST_LINE:  last_line  <= cfg_data;
        default: ;
      endcase
    end
  end

  // query holding register
  in_item_t q;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q <= in_item;
    end
  end

  // per-table counts and per-source qualities
  logic [CntBits-1:0] counts [2*MaxSources];
  logic [15:0]        quals  [MaxSources];
  logic [TabBits-1:0] load_tab;
  assign load_tab = {q.field_second, q.source_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2 * MaxSources; i++) counts[i] <= '0;
      for (int i = 0; i < MaxSources; i++) quals[i] <= '0;
    end else begin
      if (cmd.do_clear) begin
        for (int i = 0; i < 2 * MaxSources; i++) counts[i] <= '0;
      end
      if (cmd.do_load && counts[load_tab] < CntBits'(MaxSpans)) begin
        counts[load_tab] <= counts[load_tab] + 1'b1;
      end
      if (cmd.do_quality) begin
        quals[q.source_index] <= q.quality_value;
      end
    end
  end

  // search position: dir 0 this-up,1 this-down,2 other-up,3 other-down
  logic [SrcBits-1:0]  src;
  logic [1:0]          dir;
  logic signed [LineWide-1:0] cur, step_s, ooff, start_line;
  logic [SpanIdx:0]    eidx;
  logic [TabBits-1:0]  tab;
  logic                same;

  always_comb begin
    if (!q.match_chroma) begin
      step_s = LineWide'(1);
      ooff   = -LineWide'(1);
    end else if (is_pal) begin
      step_s = LineWide'(4);
      ooff   = q.this_field_first ? -LineWide'(3) : -LineWide'(1);
    end else begin
      step_s = LineWide'(2);
      ooff   = -LineWide'(1);
    end
  end

  assign same = ~dir[1];
  assign tab  = {(same ? ~q.this_field_first : q.this_field_first), src};

  logic signed [LineWide-1:0] qline;
  assign qline = $signed({2'b00, q.line_number});
  always_comb begin
    case (dir)
      2'd0:    start_line = qline;
      2'd1:    start_line = qline + step_s;
      2'd2:    start_line = qline + ooff;
      default: start_line = qline + ooff + step_s;
    endcase
  end

  // iteration control: next_dir walks directions, then sources
  logic advance;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      src <= '0;
      dir <= '0;
    end else if (advance) begin
      dir <= dir + 1'b1;
      if (dir == 2'd3) src <= src + 1'b1;
    end
  end
  assign advance = cmd.next_dir;

  // table memory
  logic [EntryBits-1:0] rdata;
  logic [AddrBits-1:0]  waddr, raddr;
  assign waddr = {load_tab, counts[load_tab][SpanIdx-1:0]};
  assign raddr = {tab, eidx[SpanIdx-1:0]};

  drls_ram #(.Width(EntryBits), .Depth(2 * MaxSources * MaxSpans)) u_ram (
    .clk   (clk),
    .we    (cmd.do_load && counts[load_tab] < CntBits'(MaxSpans)),
    .waddr (waddr),
    .wdata ({q.line_number, q.span_start, q.span_end}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // line and entry position; RAM read data is registered, so it lags the index
  always_ff @(posedge clk) begin
    if (cmd.start_dir) begin
      cur  <= start_line;
      eidx <= '0;
    end else if (cmd.next_line) begin
      cur  <= dir[0] ? cur + step_s : cur - step_s;
      eidx <= '0;
    end else if (cmd.read_entry) begin
      eidx <= eidx + 1'b1;
    end
  end

  // status
  logic signed [LineWide-1:0] z;
  logic [LineBits-1:0] e_line;
  logic [SampleBits-1:0] e_start, e_end;
  assign z = cur - LineWide'(1);
  assign {e_line, e_start, e_end} = rdata;

  always_comb begin
    stat.is_clear    = (q.mode == MODE_CLEAR);
    stat.is_load     = (q.mode == MODE_LOAD);
    stat.is_quality  = (q.mode == MODE_QUALITY);
    stat.is_query    = (q.mode == MODE_QUERY);
    stat.in_range    = (z >= $signed({2'b00, first_line})) &&
                       (z <  $signed({2'b00, last_line}));
    stat.hit         = ($signed({2'b00, e_line}) == cur) &&
                       (e_start <= q.span_end) && (q.span_start <= e_end);
    stat.last_entry  = ({1'b0, eidx} >= (SpanIdx+2)'(counts[tab]));
    stat.dir_enabled = q.source_mask[src] &&
                       (same || (!q.in_colour_burst && !intra_only));
    stat.last_dir    = (dir == 2'd3) && (src == SrcBits'(MaxSources - 1));
  end

  // candidate compare
  logic signed [LineWide:0] df, sf, dd;
  logic [9:0] line_dist;
  logic       sf_par;
  assign sf_par = same ? ~q.this_field_first : q.this_field_first;
  assign df = $signed({2'b00, q.line_number, ~q.this_field_first});
  assign sf = $signed({cur, sf_par});
  assign dd = df - sf;
  assign line_dist = dd[LineWide] ? 10'(-dd) : 10'(dd);

  logic        have, pb_same;
  logic [1:0]  pb_src;
  logic [LineBits-1:0] pb_line;
  logic [9:0]  pb_dist;
  logic [15:0] pb_qual;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      have <= 1'b0;
    end else if (cmd.take) begin
      if (!have || line_dist < pb_dist ||
          (line_dist == pb_dist && quals[src] > pb_qual)) begin
        have    <= 1'b1;
        pb_src  <= src;
        pb_same <= same;
        pb_line <= cur[LineBits-1:0];
        pb_dist <= line_dist;
        pb_qual <= quals[src];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      res.found           <= have;
      res.best_source     <= have ? pb_src : '0;
      res.from_same_field <= have & pb_same;
      res.best_line       <= have ? pb_line : '0;
      res.frame_distance  <= have ? pb_dist : '0;
      res.best_quality    <= have ? pb_qual : '0;
    end
  end

endmodule

FILE: rtl/drls_ctrl.sv
module drls_ctrl import drls_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_DIR   = 7'b0000100,
    S_LINE  = 7'b0001000,
    S_READ  = 7'b0010000,
    S_CHECK = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   out_busy;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // result register: holds until transfer
  always_ff @(posedge clk) begin
    if (rst) out_busy <= 1'b0;
    else if (cmd.result) out_busy <= 1'b1;
    else if (out_ready) out_busy <= 1'b0;
  end
  assign out_valid = out_busy;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.capture = 1'b1;
        state_next  = S_EXEC;
      end
      S_EXEC: begin
        cmd.do_clear   = stat.is_clear;
        cmd.do_load    = stat.is_load;
        cmd.do_quality = stat.is_quality;
        if (stat.is_query) state_next = S_DIR;
        else state_next = S_IDLE;
      end
      S_DIR: begin
        cmd.start_dir = 1'b1;
        cmd.next_dir  = ~stat.dir_enabled;
        state_next = stat.dir_enabled ? S_LINE : (stat.last_dir ? S_DONE : S_DIR);
      end
      S_LINE: begin
        if (!stat.in_range) begin
          cmd.next_dir = 1'b1;
          state_next   = stat.last_dir ? S_DONE : S_DIR;
        end else begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_CHECK;
      S_CHECK: begin
        if (stat.last_entry) begin
          cmd.take     = 1'b1;
          cmd.next_dir = 1'b1;
          state_next   = stat.last_dir ? S_DONE : S_DIR;
        end else if (stat.hit) begin
          cmd.next_line = 1'b1;
          state_next = S_LINE;
        end else begin
          cmd.read_entry = 1'b1;
          state_next = S_READ;
        end
      end
      S_DONE: if (!out_busy || out_ready) begin
        cmd.result = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // checks
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state));
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid);
  a_capture_xfer: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> in_valid && in_ready);
  a_result_room: assert property (@(posedge clk) disable iff (rst)
    cmd.result |-> !out_valid || out_ready);

endmodule

FILE: rtl/dropout_replacement_line_search.sv
// channel | dir | handshake
// in      | in  | in_valid/in_ready, in_item
// out     | out | out_valid/out_ready, out_item
// cfg     | in  | cfg_we, cfg_index, cfg_data
// Clear, load and quality are accepted, then executed, and give no result.
// A query is accepted and executed, then visits each source/direction slot (16), each line
// visited, and each stored span read (up to count+1 per line), and then loads the result.
// One result register: input is taken only in idle, so it stalls while any item executes.
// Reset is synchronous; span RAM is not cleared, counts and qualities are.
module dropout_replacement_line_search import drls_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [LineBits-1:0] cfg_data
);
  dp_cmd_t  cmd;
  dp_stat_t stat;
  drls_ctrl u_ctrl (.clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
                    .stat, .cmd);
  drls_datapath u_dp (.clk, .rst, .cfg_we, .cfg_idx(cfg_index), .cfg_data,
                      .in_item, .cmd, .stat, .res(out_item));
endmodule
